// ----- src/tsq_pkg.sv -----
`default_nettype none
package tsq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    take;        // latch incoming payload
		logic    enq;         // push latched value onto inbox
		logic    xfer_rd;     // read inbox top, drop inbox fill
		logic    xfer_wr;     // push last inbox read onto outbox
		logic    pop_rd;      // read outbox top, drop outbox fill
		logic    load_res;    // load the result register
		status_t res_status;
		logic    res_use_val; // result carries the popped value
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_full;
		logic in_empty;
		logic out_empty;
	} stat_t;

endpackage
`default_nettype wire

// ----- src/tsq_in_if.sv -----
`default_nettype none
interface tsq_in_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic signed [tsq_pkg::DATA_W-1:0] data_value;

	modport source (output valid, output kind, output data_value, input ready);
	modport sink   (input valid, input kind, input data_value, output ready);
endinterface
`default_nettype wire

// ----- src/tsq_out_if.sv -----
`default_nettype none
interface tsq_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [tsq_pkg::DATA_W-1:0] out_value;
	logic [tsq_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output out_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input out_value, input occupancy,
		output ready);
endinterface
`default_nettype wire

// ----- src/tsq_dp.sv -----
`default_nettype none
module tsq_dp #(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tsq_pkg::cmd_t                     cmd,
	input  wire logic signed [tsq_pkg::DATA_W-1:0] data_value,
	output      tsq_pkg::stat_t                    stat,
	output      logic [1:0]                        res_status,
	output      logic signed [tsq_pkg::DATA_W-1:0] res_value,
	output      logic [tsq_pkg::OCC_W-1:0]         res_occ
);

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam int TOT_W  = $clog2(2 * STACK_DEPTH + 1);

	logic [tsq_pkg::DATA_W-1:0] in_mem  [STACK_DEPTH];
	logic [tsq_pkg::DATA_W-1:0] out_mem [STACK_DEPTH];

	logic [FILL_W-1:0]          in_fill_q;
	logic [FILL_W-1:0]          out_fill_q;
	logic [TOT_W-1:0]           total_q;
	logic [tsq_pkg::DATA_W-1:0] data_q;
	logic [tsq_pkg::DATA_W-1:0] in_rdata_q;
	logic [tsq_pkg::DATA_W-1:0] out_rdata_q;
	logic [1:0]                 res_status_q;
	logic [tsq_pkg::DATA_W-1:0] res_value_q;
	logic [tsq_pkg::OCC_W-1:0]  res_occ_q;

	logic [FILL_W-1:0] in_dec;
	logic [FILL_W-1:0] out_dec;
	logic [ADDR_W-1:0] in_top;
	logic [ADDR_W-1:0] out_top;

	assign in_dec  = in_fill_q - FILL_W'(1);
	assign out_dec = out_fill_q - FILL_W'(1);
	assign in_top  = in_dec[ADDR_W-1:0];
	assign out_top = out_dec[ADDR_W-1:0];

	assign stat.in_full   = (in_fill_q == FILL_W'(STACK_DEPTH));
	assign stat.in_empty  = (in_fill_q == '0);
	assign stat.out_empty = (out_fill_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fill_q  <= '0;
			out_fill_q <= '0;
			total_q    <= '0;
		end else begin
			if (cmd.enq) begin
				in_fill_q <= in_fill_q + FILL_W'(1);
				total_q   <= total_q + TOT_W'(1);
			end
			if (cmd.xfer_rd)
				in_fill_q <= in_dec;
			if (cmd.xfer_wr)
				out_fill_q <= out_fill_q + FILL_W'(1);
			if (cmd.pop_rd) begin
				out_fill_q <= out_dec;
				total_q    <= total_q - TOT_W'(1);
			end
		end
	end

	// inbox stack memory
	always_ff @(posedge clk) begin
		if (cmd.enq)
			in_mem[in_fill_q[ADDR_W-1:0]] <= data_q;
		if (cmd.xfer_rd)
			in_rdata_q <= in_mem[in_top];
	end

	// outbox stack memory
	always_ff @(posedge clk) begin
		if (cmd.xfer_wr)
			out_mem[out_fill_q[ADDR_W-1:0]] <= in_rdata_q;
		if (cmd.pop_rd)
			out_rdata_q <= out_mem[out_top];
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			data_q <= data_value;
		if (cmd.load_res) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_use_val ? out_rdata_q : '0;
			res_occ_q    <= tsq_pkg::OCC_W'(total_q);
		end
	end

	assign res_status = res_status_q;
	assign res_value  = res_value_q;
	assign res_occ    = res_occ_q;

`ifndef SYNTHESIS
	// one entry is in flight in the read register between a transfer read and its write
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) == 32'(in_fill_q) + 32'(out_fill_q) + 32'(cmd.xfer_wr))
		else $error("entry total out of step with stack fills");

	a_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_fill_q) <= STACK_DEPTH)
		else $error("inbox fill beyond depth");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |-> !stat.in_full)
		else $error("push onto full inbox");

	a_xfer_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.xfer_wr |-> out_fill_q != FILL_W'(STACK_DEPTH))
		else $error("transfer onto full outbox");

	a_pop_drops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |=> total_q == $past(total_q) - TOT_W'(1))
		else $error("pop did not lower the entry total");
`endif

endmodule
`default_nettype wire

// ----- src/tsq_ctrl.sv -----
`default_nettype none
module tsq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_kind,
	output      logic           in_ready,
	input  wire logic           out_ready,
	output      logic           out_valid,
	input  wire tsq_pkg::stat_t stat,
	output      tsq_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_XRD,
		S_XWR,
		S_POP,
		S_FIN
	} state_t;

	state_t           state_q;
	logic             kind_q;
	tsq_pkg::status_t st_q;
	logic             out_valid_q;
	logic             fin_go;

	assign fin_go = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.res_status  = st_q;
		cmd.res_use_val = (kind_q == tsq_pkg::KIND_DEQ) && (st_q == tsq_pkg::ST_OK);
		cmd.take        = (state_q == S_IDLE) && in_valid;
		cmd.enq         = (state_q == S_EXEC) && (kind_q == tsq_pkg::KIND_ENQ) &&
			!stat.in_full;
		cmd.xfer_rd     = (state_q == S_XRD) && !stat.in_empty;
		cmd.xfer_wr     = (state_q == S_XWR);
		cmd.pop_rd      = (state_q == S_POP);
		cmd.load_res    = (state_q == S_FIN) && fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= tsq_pkg::KIND_ENQ;
			st_q        <= tsq_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= in_kind;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (kind_q == tsq_pkg::KIND_ENQ) begin
						st_q    <= stat.in_full ? tsq_pkg::ST_FULL : tsq_pkg::ST_OK;
						state_q <= S_FIN;
					end else if (stat.in_empty && stat.out_empty) begin
						st_q    <= tsq_pkg::ST_EMPTY;
						state_q <= S_FIN;
					end else begin
						st_q    <= tsq_pkg::ST_OK;
						state_q <= stat.out_empty ? S_XRD : S_POP;
					end
				end
				// refill outbox one entry per read/write pair
				S_XRD: begin
					state_q <= stat.in_empty ? S_POP : S_XWR;
				end
				S_XWR: begin
					state_q <= S_XRD;
				end
				S_POP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- src/two_stack_fifo_queue_core.sv -----
// Accept to result valid: an enqueue or a refused dequeue goes through EXEC, FIN;
// a dequeue through EXEC, POP, FIN, and when the outbox is empty, N inbox entries
// are moved over first (one memory read and one write per entry) before POP.
// One transaction at a time: the next is accepted the cycle after the result is
// loaded, while that result waits in the output register.
// arst_n clears both stack fills and the entry count; stack memories are not reset.
`default_nettype none
module two_stack_fifo_queue_core #(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsq_in_if.sink     req,
	tsq_out_if.source  rsp
);

	tsq_pkg::cmd_t  cmd;
	tsq_pkg::stat_t stat;

	tsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_kind   (req.kind),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsq_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_value (req.data_value),
		.stat       (stat),
		.res_status (rsp.status),
		.res_value  (rsp.out_value),
		.res_occ    (rsp.occupancy)
	);

endmodule
`default_nettype wire

// ----- dv/two_stack_fifo_queue_core_tb.sv -----
`timescale 1ns / 1ps
module two_stack_fifo_queue_core_tb;

	localparam int DEPTH    = 8;
	localparam int MAX_GAP  = 20;
	localparam int MAX_SHOW = 10;

	typedef struct packed {
		tsq_pkg::status_t                  status;
		logic signed [tsq_pkg::DATA_W-1:0] value;
		logic [tsq_pkg::OCC_W-1:0]         occ;
	} queue_result_t;

	logic clk;
	logic arst_n;

	tsq_in_if  req_if ();
	tsq_out_if rsp_if ();

	two_stack_fifo_queue_core #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// predicted queue contents
	logic signed [tsq_pkg::DATA_W-1:0] inbox_mem  [DEPTH];
	logic signed [tsq_pkg::DATA_W-1:0] outbox_mem [DEPTH];
	int                                inbox_cnt;
	int                                outbox_cnt;
	logic [tsq_pkg::OCC_W-1:0]         held;

	queue_result_t pending_results[$];
	int            req_taken;
	int            mismatches;
	int            idle_pct;
	int            stall_pct;

	always #2 clk = ~clk;

	function automatic queue_result_t predict_queue_op(logic op,
		logic signed [tsq_pkg::DATA_W-1:0] value);
		queue_result_t r;
		r.status = tsq_pkg::ST_OK;
		r.value  = '0;
		if (op == tsq_pkg::KIND_ENQ) begin
			if (inbox_cnt >= DEPTH) begin
				r.status = tsq_pkg::ST_FULL;
			end else begin
				inbox_mem[inbox_cnt] = value;
				inbox_cnt++;
				held++;
			end
		end else if (inbox_cnt == 0 && outbox_cnt == 0) begin
			r.status = tsq_pkg::ST_EMPTY;
		end else begin
			// refill reverses inbox order so the oldest entry lands on top
			if (outbox_cnt == 0) begin
				while (inbox_cnt > 0) begin
					inbox_cnt--;
					outbox_mem[outbox_cnt] = inbox_mem[inbox_cnt];
					outbox_cnt++;
				end
			end
			outbox_cnt--;
			r.value = outbox_mem[outbox_cnt];
			held--;
		end
		r.occ = held;
		return r;
	endfunction

	function automatic logic signed [tsq_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// scoreboard: result side first, then the request accepted on the same edge
	always @(posedge clk) begin : monitor
		queue_result_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOW)
						$display("%0t: unexpected transaction status=%0d value=%0d occ=%0d",
							$realtime, rsp_if.status, rsp_if.out_value, rsp_if.occupancy);
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.status !== want.status || rsp_if.out_value !== want.value ||
						rsp_if.occupancy !== want.occ) begin
						mismatches++;
						if (mismatches <= MAX_SHOW)
							$display("%0t: mismatch exp status=%0d value=%0d occ=%0d,",
								$realtime, want.status, want.value, want.occ,
								" got status=%0d value=%0d occ=%0d",
								rsp_if.status, rsp_if.out_value, rsp_if.occupancy);
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				pending_results.push_back(predict_queue_op(req_if.kind, req_if.data_value));
				req_taken++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic op, input logic signed [tsq_pkg::DATA_W-1:0] value);
		int gap;
		int seen;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		repeat (gap) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.kind       <= op;
		req_if.data_value <= value;
		seen = req_taken;
		do @(negedge clk); while (req_taken == seen);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_refused_dequeue();
		idle_pct  = 0;
		stall_pct = 0;
		send_item(tsq_pkg::KIND_DEQ, 32'sh1234_5678);
		send_item(tsq_pkg::KIND_DEQ, -32'sd1);
	endtask

	// fill inbox with edge values, then one enqueue past full
	task automatic test_extremes_and_full();
		send_item(tsq_pkg::KIND_ENQ, 32'sh8000_0000);
		send_item(tsq_pkg::KIND_ENQ, 32'sh7fff_ffff);
		send_item(tsq_pkg::KIND_ENQ, -32'sd1);
		send_item(tsq_pkg::KIND_ENQ, '0);
		send_item(tsq_pkg::KIND_ENQ, 32'sh5555_5555);
		send_item(tsq_pkg::KIND_ENQ, 32'shaaaa_aaaa);
		send_item(tsq_pkg::KIND_ENQ, 32'sd1);
		send_item(tsq_pkg::KIND_ENQ, 32'sh0f0f_f0f0);
		send_item(tsq_pkg::KIND_ENQ, 32'sh1111_1111);
	endtask

	// full transfer on dequeue, then inbox full again while outbox still has room
	task automatic test_transfer_order();
		send_item(tsq_pkg::KIND_DEQ, '0);
		repeat (DEPTH) send_item(tsq_pkg::KIND_ENQ, pick_value());
		send_item(tsq_pkg::KIND_ENQ, 32'sh2222_2222);
		repeat (4) send_item(tsq_pkg::KIND_DEQ, '0);
		wait_drained();
	endtask

	task automatic test_random_phase(input int count, input int idle, input int stall);
		int  sent;
		int  burst;
		logic op;
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			// lean toward refill when low, toward draining when high
			if (held < 4)
				op = ($urandom_range(99) < 75) ? tsq_pkg::KIND_ENQ : tsq_pkg::KIND_DEQ;
			else if (held > 11)
				op = ($urandom_range(99) < 25) ? tsq_pkg::KIND_ENQ : tsq_pkg::KIND_DEQ;
			else
				op = $urandom_range(1) ? tsq_pkg::KIND_DEQ : tsq_pkg::KIND_ENQ;
			repeat (burst) begin
				if (sent < count) begin
					send_item(op, pick_value());
					sent++;
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.kind       = tsq_pkg::KIND_ENQ;
		req_if.data_value = '0;
		rsp_if.ready      = 1'b0;
		inbox_cnt         = 0;
		outbox_cnt        = 0;
		held              = '0;
		req_taken         = 0;
		mismatches        = 0;
		idle_pct          = 0;
		stall_pct         = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_refused_dequeue();
		test_extremes_and_full();
		test_transfer_order();
		test_random_phase(225, 0, 0);
		test_random_phase(225, 69, 0);
		test_random_phase(225, 0, 69);
		test_random_phase(225, 16, 16);

		repeat (30) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
